/* sv/colorkey_alpha_blit_pixel_defines.svh */
// Assertion macros for the colorkey alpha blitter checker.
// Used by ckab_checker; expects clk and arst_n in the including scope.
`ifndef COLORKEY_ALPHA_BLIT_PIXEL_DEFINES_SVH
`define COLORKEY_ALPHA_BLIT_PIXEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CKAB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CKAB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/ckab_pkg.sv */
// Shared types, constants and arithmetic helpers of the colorkey alpha blitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ckab_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

	localparam logic [1:0] FMT_INDEXED = 2'd0;
	localparam logic [1:0] FMT_RGB24 = 2'd1;
	localparam logic [1:0] FMT_ARGB8888 = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR = 8'h00;

	typedef enum logic [2:0] {
		REG_SRC_FORMAT = 3'd0,
		REG_DST_FORMAT = 3'd1,
		REG_CKEY_EN = 3'd2,
		REG_CKEY = 3'd3,
		REG_ALPHA_MOD = 3'd4,
		REG_BLEND_EN = 3'd5,
		REG_CONVERT = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		PATH_DROP,
		PATH_UNSUP,
		PATH_INDEX,
		PATH_PACK,
		PATH_BLEND,
		PATH_MIX
	} path_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgba_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// Exact floor(x / 255) for x up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [31:0] pack_px(input logic [1:0] fmt, input rgba_t c);
		if (fmt == FMT_RGB24) begin
			return {8'h00, c.b, c.g, c.r};
		end
		return {c.a, c.r, c.g, c.b};
	endfunction

endpackage

`default_nettype wire

/* sv/ckab_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ckab_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/colorkey_alpha_blit_pixel.sv */
// An accepted word passes through the stage 1 to stage 4 registers and then the output register to reach the output.
// Throughput: one word per cycle; stages stall only when the output word is not taken.
// Palette words are written into the palette RAM at acceptance and give no result.
// Reset clears the pipeline valid bits and loads the register defaults at once.
// The palette RAM is not cleared; entries hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none

module colorkey_alpha_blit_pixel import ckab_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic kind,
	input wire logic [31:0] src_pixel,
	input wire logic [31:0] dst_pixel,
	input wire logic [7:0] pal_index,
	input wire logic [31:0] pal_color,
	output logic out_valid,
	input wire logic out_ready,
	output logic write_enable,
	output logic [31:0] out_pixel,
	output logic unsupported
);

	logic [1:0] src_format_q;
	logic [1:0] dst_format_q;
	logic ckey_en_q;
	logic [31:0] ckey_q;
	logic [7:0] alpha_mod_q;
	logic blend_en_q;
	logic convert_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_format_q <= FMT_INDEXED;
			dst_format_q <= FMT_ARGB8888;
			ckey_en_q <= 1'b0;
			ckey_q <= '0;
			alpha_mod_q <= ALPHA_OPAQUE;
			blend_en_q <= 1'b0;
			convert_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_FORMAT: src_format_q <= cfg_data[1:0];
				REG_DST_FORMAT: dst_format_q <= cfg_data[1:0];
				REG_CKEY_EN: ckey_en_q <= cfg_data[0];
				REG_CKEY: ckey_q <= cfg_data;
				REG_ALPHA_MOD: alpha_mod_q <= cfg_data[7:0];
				REG_BLEND_EN: blend_en_q <= cfg_data[0];
				REG_CONVERT: convert_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic load_o, load4, load3, load2, load1, accept;

	assign load_o = !out_valid_q || out_ready;
	assign load4 = !v_s4 || load_o;
	assign load3 = !v_s3 || load4;
	assign load2 = !v_s2 || load3;
	assign load1 = !v_s1 || load2;
	assign in_ready = load1;
	assign accept = in_valid && load1;

	logic pal_we;
	logic [31:0] pal_rdata;

	assign pal_we = accept && kind && ({1'b0, pal_index} < PAL_LIMIT);

	ckab_ram #(
		.WIDTH(32),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk(clk),
		.we(pal_we),
		.waddr(pal_index[PAL_AW-1:0]),
		.wdata(pal_color),
		.re(accept && !kind),
		.raddr(src_pixel[PAL_AW-1:0]),
		.rdata(pal_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load1) begin
				v_s1 <= accept && !kind;
			end
			if (load2) begin
				v_s2 <= v_s1;
			end
			if (load3) begin
				v_s3 <= v_s2;
			end
			if (load4) begin
				v_s4 <= v_s3;
			end
			if (load_o) begin
				out_valid_q <= v_s4;
			end
		end
	end

	// Stage 1: palette data arrives; decode formats, colorkey and result path.
	logic [31:0] sp_s1, dp_s1;
	logic oor_s1;

	always_ff @(posedge clk) begin
		if (load1) begin
			sp_s1 <= src_pixel;
			dp_s1 <= dst_pixel;
			oor_s1 <= !({1'b0, src_pixel[7:0]} < PAL_LIMIT);
		end
	end

	logic [31:0] pal_c;
	logic keyed;
	rgba_t src_c;
	rgb_t dst_c;
	path_t path_c;
	logic [15:0] prod_c;

	always_comb begin
		pal_c = oor_s1 ? 32'h0 : pal_rdata;
		case (src_format_q)
			FMT_INDEXED: begin
				keyed = ckey_en_q && (sp_s1[7:0] == ckey_q[7:0]);
				src_c.r = pal_c[7:0];
				src_c.g = pal_c[15:8];
				src_c.b = pal_c[23:16];
				src_c.a = convert_q ? pal_c[31:24] : ALPHA_OPAQUE;
			end
			FMT_RGB24: begin
				keyed = ckey_en_q && ({8'h00, sp_s1[23:0]} == ckey_q);
				src_c.r = sp_s1[7:0];
				src_c.g = sp_s1[15:8];
				src_c.b = sp_s1[23:16];
				src_c.a = ALPHA_OPAQUE;
			end
			default: begin
				keyed = ckey_en_q && (sp_s1[23:0] == ckey_q[23:0]);
				src_c.r = sp_s1[23:16];
				src_c.g = sp_s1[15:8];
				src_c.b = sp_s1[7:0];
				src_c.a = sp_s1[31:24];
			end
		endcase

		if (dst_format_q == FMT_RGB24) begin
			dst_c.r = dp_s1[7:0];
			dst_c.g = dp_s1[15:8];
			dst_c.b = dp_s1[23:16];
		end else begin
			dst_c.r = dp_s1[23:16];
			dst_c.g = dp_s1[15:8];
			dst_c.b = dp_s1[7:0];
		end

		if (dst_format_q == FMT_INDEXED) begin
			src_c.r = sp_s1[7:0];
			if (src_format_q != FMT_INDEXED || convert_q) begin
				path_c = PATH_UNSUP;
			end else if (keyed) begin
				path_c = PATH_DROP;
			end else begin
				path_c = PATH_INDEX;
			end
		end else if (convert_q) begin
			path_c = PATH_PACK;
			if (keyed) begin
				src_c = '0;
			end
		end else if (keyed) begin
			path_c = PATH_DROP;
		end else if (blend_en_q) begin
			path_c = PATH_BLEND;
		end else begin
			path_c = PATH_PACK;
		end

		prod_c = 16'(src_c.a) * 16'(alpha_mod_q);
	end

	// Stage 2: modulated alpha and the blend decision.
	path_t path_s2;
	rgba_t src_s2;
	rgb_t dst_s2;
	logic [15:0] prod_s2;

	always_ff @(posedge clk) begin
		if (load2) begin
			path_s2 <= path_c;
			src_s2 <= src_c;
			dst_s2 <= dst_c;
			prod_s2 <= prod_c;
		end
	end

	logic [7:0] a_eff;
	path_t path2_c;
	rgba_t src2_c;

	always_comb begin
		a_eff = (alpha_mod_q == ALPHA_OPAQUE) ? src_s2.a : div255(prod_s2);
		path2_c = path_s2;
		src2_c = src_s2;
		if (path_s2 == PATH_BLEND) begin
			src2_c.a = a_eff;
			if (a_eff == ALPHA_CLEAR) begin
				path2_c = PATH_DROP;
			end else if (a_eff == ALPHA_OPAQUE) begin
				path2_c = PATH_PACK;
			end else begin
				path2_c = PATH_MIX;
			end
		end
	end

	// Stage 3: weighted sums of source and destination, one lane per channel.
	path_t path_s3;
	rgba_t src_s3;
	rgb_t dst_s3;

	always_ff @(posedge clk) begin
		if (load3) begin
			path_s3 <= path2_c;
			src_s3 <= src2_c;
			dst_s3 <= dst_s2;
		end
	end

	logic [7:0] inv_a;
	logic [15:0] sum_r_c, sum_g_c, sum_b_c;

	always_comb begin
		inv_a = ALPHA_OPAQUE - src_s3.a;
		if (path_s3 == PATH_MIX) begin
			sum_r_c = 16'(16'(src_s3.r) * 16'(src_s3.a) + 16'(dst_s3.r) * 16'(inv_a));
			sum_g_c = 16'(16'(src_s3.g) * 16'(src_s3.a) + 16'(dst_s3.g) * 16'(inv_a));
			sum_b_c = 16'(16'(src_s3.b) * 16'(src_s3.a) + 16'(dst_s3.b) * 16'(inv_a));
		end else begin
			sum_r_c = {8'h00, src_s3.r};
			sum_g_c = {8'h00, src_s3.g};
			sum_b_c = {8'h00, src_s3.b};
		end
	end

	// Stage 4: divide the sums and pack the output word.
	path_t path_s4;
	logic [15:0] sum_r_s4, sum_g_s4, sum_b_s4;
	logic [7:0] a_s4;

	always_ff @(posedge clk) begin
		if (load4) begin
			path_s4 <= path_s3;
			sum_r_s4 <= sum_r_c;
			sum_g_s4 <= sum_g_c;
			sum_b_s4 <= sum_b_c;
			a_s4 <= src_s3.a;
		end
	end

	rgba_t fin_c;
	logic we_c, unsup_c;
	logic [31:0] px_c;

	always_comb begin
		if (path_s4 == PATH_MIX) begin
			fin_c.r = div255(sum_r_s4);
			fin_c.g = div255(sum_g_s4);
			fin_c.b = div255(sum_b_s4);
			fin_c.a = ALPHA_OPAQUE;
		end else begin
			fin_c.r = sum_r_s4[7:0];
			fin_c.g = sum_g_s4[7:0];
			fin_c.b = sum_b_s4[7:0];
			fin_c.a = a_s4;
		end
		we_c = 1'b0;
		unsup_c = 1'b0;
		px_c = 32'h0;
		case (path_s4)
			PATH_INDEX: begin
				we_c = 1'b1;
				px_c = {24'h0, fin_c.r};
			end
			PATH_PACK, PATH_MIX: begin
				we_c = 1'b1;
				px_c = pack_px(dst_format_q, fin_c);
			end
			PATH_UNSUP: begin
				unsup_c = 1'b1;
			end
			default: ;
		endcase
	end

	logic write_enable_q, unsupported_q;
	logic [31:0] out_pixel_q;

	always_ff @(posedge clk) begin
		if (load_o) begin
			write_enable_q <= we_c;
			unsupported_q <= unsup_c;
			out_pixel_q <= px_c;
		end
	end

	assign out_valid = out_valid_q;
	assign write_enable = write_enable_q;
	assign unsupported = unsupported_q;
	assign out_pixel = out_pixel_q;

endmodule

`default_nettype wire

/* sv/ckab_checker.sv */
// Port-level checker for the colorkey alpha blitter, bound to the top level.
// Depends on colorkey_alpha_blit_pixel_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "colorkey_alpha_blit_pixel_defines.svh"

module ckab_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic write_enable,
	input wire logic [31:0] out_pixel,
	input wire logic unsupported
);

	`CKAB_ASSERT_IMPL(a_no_pixel_without_write, out_valid && !write_enable, out_pixel == 32'h0, "Output pixel is not zero on a word without write.")
	`CKAB_ASSERT_IMPL(a_flags_exclusive, out_valid, !(write_enable && unsupported), "Write and unsupported are both set.")
	`CKAB_ASSERT_IMPL(a_stall_source, !in_ready, out_valid && !out_ready, "Input stalled while the output is not blocked.")
	`CKAB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel) && $stable(write_enable) && $stable(unsupported), "Output word changed while stalled.")

endmodule

bind colorkey_alpha_blit_pixel ckab_checker u_checker (.*);

`default_nettype wire
